@@ rtl/carv_pkg.sv @@
// Shared widths, register map, reset values and saturation helpers for the reverb.
`default_nettype none
package carv_pkg;

   // Sample and delay-line word formats (23 fraction bits throughout).
   localparam int SAMPLE_W = 24;
   localparam int LINE_W   = SAMPLE_W + 4;

   // Delay memories.
   localparam int NUM_COMBS  = 4;
   localparam int NUM_AP     = 2;
   localparam int COMB_DEPTH = 8192;
   localparam int COMB_AW    = $clog2(COMB_DEPTH);
   localparam int COMB_LW    = COMB_AW + 1;
   localparam int AP_DEPTH   = 2048;
   localparam int AP_AW      = $clog2(AP_DEPTH);
   localparam int AP_LW      = AP_AW + 1;

   // Gains.
   localparam int FB_W       = 16;
   localparam int AMT_W      = 17;
   localparam int GAIN_W     = AMT_W + 1;
   localparam int FB_PROD_W  = LINE_W + FB_W + 1;
   localparam int DRY_PROD_W = SAMPLE_W + GAIN_W + 1;
   localparam int WET_PROD_W = LINE_W + GAIN_W + 1;
   localparam int MIX_W      = WET_PROD_W + 1;
   localparam int MIX_SHIFT  = 17;
   localparam int MIX_SH_W   = MIX_W - MIX_SHIFT;

   localparam logic [AMT_W-1:0]  AMT_MAX  = AMT_W'(65536);
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(131072);

   // Configuration port.
   localparam int DATA_W  = 32;
   localparam int NUM_CFG = 8;
   localparam int PADDR_W = $clog2(NUM_CFG) + 2;

   typedef enum logic [2:0] {
      REG_COMB_LEN_A    = 3'd0,
      REG_COMB_LEN_B    = 3'd1,
      REG_COMB_LEN_C    = 3'd2,
      REG_COMB_LEN_D    = 3'd3,
      REG_AP_LEN_A      = 3'd4,
      REG_AP_LEN_B      = 3'd5,
      REG_COMB_FEEDBACK = 3'd6,
      REG_WET_AMOUNT    = 3'd7
   } reg_index_type;

   localparam logic [COMB_LW-1:0] COMB_LEN_RESET [NUM_COMBS] = '{
      COMB_LW'(1116), COMB_LW'(1188), COMB_LW'(1277), COMB_LW'(1356)
   };
   localparam logic [AP_LW-1:0] AP_LEN_RESET [NUM_AP] = '{AP_LW'(556), AP_LW'(441)};
   localparam logic [FB_W-1:0]  FB_RESET  = FB_W'(47186);
   localparam logic [AMT_W-1:0] AMT_RESET = '0;

   // Output queue.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_AW    = $clog2(OUT_DEPTH);
   localparam int OUT_CW    = OUT_AW + 1;

   // Saturate a value with one bit of growth back to the line width.
   function automatic logic signed [LINE_W-1:0] sat_line(input logic signed [LINE_W:0] v);
      logic signed [LINE_W-1:0] r;
      if (v[LINE_W] != v[LINE_W-1]) begin
         r = v[LINE_W] ? {1'b1, {(LINE_W-1){1'b0}}} : {1'b0, {(LINE_W-1){1'b1}}};
      end else begin
         r = v[LINE_W-1:0];
      end
      return r;
   endfunction

   // Saturate the shifted mix to the sample width.
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [MIX_SH_W-1:0] v);
      logic signed [MIX_SH_W-1:0] hi;
      logic signed [MIX_SH_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] r;
      hi = MIX_SH_W'((64'sd1 <<< (SAMPLE_W-1)) - 64'sd1);
      lo = -hi - MIX_SH_W'(1);
      if (v > hi) begin
         r = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (v < lo) begin
         r = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/comb_allpass_reverb.sv @@
// Schroeder reverb: four feedback combs, two series allpasses and a dry/wet mix.
`default_nettype none
// Takes one request (a Q1.23 sample) at a time, never back to back, and returns one
// mixed sample per request, in order; each result passes through the pipeline stages
// and the output queue before it is offered on the result port. After reset the block
// zeroes the delay memories, one address per cycle across all banks, and holds req_stall
// high throughout; configuration writes are taken during that time. The spacing is
// set by the delay memories: each comb bank and each allpass bank has one read and one
// write per request, and the pipeline spaces requests so that a line is written
// back before the next request reads it. A four-entry output queue lets the block
// keep taking requests while results wait on rsp_stall; req_stall rises once four
// requests are in flight or queued. Lengths above the memory depth act as the
// depth, a length of zero bypasses that stage, and wet_amount above 1.0 acts as 1.0.
// Configuration must only be changed while no request is in flight.
module comb_allpass_reverb (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [carv_pkg::SAMPLE_W-1:0]   req_in_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [carv_pkg::SAMPLE_W-1:0]   rsp_out_sample,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [carv_pkg::PADDR_W-1:0]           paddr,
   input  logic [carv_pkg::DATA_W-1:0]            pwdata,
   output logic [carv_pkg::DATA_W-1:0]            prdata,
   output logic                                   pready
);
   import carv_pkg::*;

   // Configuration registers.
   logic [COMB_LW-1:0] cfg_comb_len_ff [NUM_COMBS];
   logic [COMB_LW-1:0] cfg_comb_len_in [NUM_COMBS];
   logic [AP_LW-1:0]   cfg_ap_len_ff   [NUM_AP];
   logic [AP_LW-1:0]   cfg_ap_len_in   [NUM_AP];
   logic [FB_W-1:0]    cfg_fb_ff;
   logic [FB_W-1:0]    cfg_fb_in;
   logic [AMT_W-1:0]   cfg_amt_ff;
   logic [AMT_W-1:0]   cfg_amt_in;
   logic               cfg_write;
   reg_index_type      cfg_index;

   // Delay memories, one bank per filter.
   logic signed [LINE_W-1:0] comb_mem [NUM_COMBS][COMB_DEPTH];
   logic signed [LINE_W-1:0] ap_mem   [NUM_AP][AP_DEPTH];
   logic signed [LINE_W-1:0] comb_rd_ff [NUM_COMBS];
   logic signed [LINE_W-1:0] ap_rd_ff   [NUM_AP];

   // Clearing pass after reset.
   logic               clearing_ff;
   logic               clearing_in;
   logic [COMB_AW-1:0] clr_idx_ff;
   logic [COMB_AW-1:0] clr_idx_in;

   // Cursors and their next values.
   logic [COMB_AW-1:0] comb_cur_ff   [NUM_COMBS];
   logic [COMB_AW-1:0] comb_cur_in   [NUM_COMBS];
   logic [COMB_AW-1:0] comb_cur_eff  [NUM_COMBS];
   logic [COMB_LW-1:0] comb_len_sat  [NUM_COMBS];
   logic [COMB_LW-1:0] comb_cur_inc  [NUM_COMBS];
   logic               comb_act      [NUM_COMBS];
   logic [AP_AW-1:0]   ap_cur_ff     [NUM_AP];
   logic [AP_AW-1:0]   ap_cur_in     [NUM_AP];
   logic [AP_AW-1:0]   ap_cur_eff    [NUM_AP];
   logic [AP_LW-1:0]   ap_len_sat    [NUM_AP];
   logic [AP_LW-1:0]   ap_cur_inc    [NUM_AP];
   logic               ap_act        [NUM_AP];

   // Handshake and flow control.
   logic               req_accept;
   logic               rsp_pop;
   logic               gap_ff;
   logic [OUT_CW-1:0]  outstanding_ff;
   logic [OUT_CW-1:0]  outstanding_in;

   // Stage 1: comb read data valid, comb write-back.
   logic                       v1_ff;
   logic signed [SAMPLE_W-1:0] s1_dry_ff;
   logic                       s1_comb_act_ff  [NUM_COMBS];
   logic [COMB_AW-1:0]         s1_comb_addr_ff [NUM_COMBS];
   logic                       s1_ap_act_ff    [NUM_AP];
   logic [AP_AW-1:0]           s1_ap_addr_ff   [NUM_AP];
   logic signed [FB_PROD_W-1:0] comb_prod      [NUM_COMBS];
   logic signed [LINE_W-1:0]   comb_wr_in      [NUM_COMBS];
   logic signed [LINE_W-1:0]   wet_sum_in;

   // Stage 2: first allpass.
   logic                       v2_ff;
   logic signed [SAMPLE_W-1:0] s2_dry_ff;
   logic signed [LINE_W-1:0]   s2_wet_ff;
   logic                       s2_ap_act_ff  [NUM_AP];
   logic [AP_AW-1:0]           s2_ap_addr_ff [NUM_AP];
   logic signed [LINE_W-1:0]   ap_a_out_in;
   logic signed [LINE_W-1:0]   ap_a_wr_in;

   // Stage 3: second allpass.
   logic                       v3_ff;
   logic signed [SAMPLE_W-1:0] s3_dry_ff;
   logic signed [LINE_W-1:0]   s3_wet_ff;
   logic                       s3_ap_act_ff;
   logic [AP_AW-1:0]           s3_ap_addr_ff;
   logic signed [LINE_W-1:0]   ap_b_out_in;
   logic signed [LINE_W-1:0]   ap_b_wr_in;

   // Stage 4: mix products.
   logic                       v4_ff;
   logic signed [SAMPLE_W-1:0] s4_dry_ff;
   logic signed [LINE_W-1:0]   s4_wet_ff;
   logic [AMT_W-1:0]           amt_sat;
   logic [GAIN_W-1:0]          gain_dry;
   logic [GAIN_W-1:0]          gain_wet;
   logic signed [DRY_PROD_W-1:0] p_dry_in;
   logic signed [WET_PROD_W-1:0] p_wet_in;

   // Stage 5: sum, shift and saturate.
   logic                         v5_ff;
   logic signed [DRY_PROD_W-1:0] p_dry_ff;
   logic signed [WET_PROD_W-1:0] p_wet_ff;
   logic signed [MIX_W-1:0]      mix_sum;
   logic signed [SAMPLE_W-1:0]   mix_in;

   // Output queue.
   logic signed [SAMPLE_W-1:0] outq_ff [OUT_DEPTH];
   logic [OUT_AW-1:0]          outq_wr_ff;
   logic [OUT_AW-1:0]          outq_rd_ff;
   logic [OUT_CW-1:0]          outq_cnt_ff;
   logic [OUT_CW-1:0]          outq_cnt_in;

   // ------------------------------------------------------------------
   // Configuration port. Every write lands in the next cycle; reads are
   // combinational and zero-extended.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = reg_index_type'(paddr[PADDR_W-1:2]);

   always_comb begin
      cfg_comb_len_in = cfg_comb_len_ff;
      cfg_ap_len_in   = cfg_ap_len_ff;
      cfg_fb_in       = cfg_fb_ff;
      cfg_amt_in      = cfg_amt_ff;
      if (cfg_write) begin
         case (cfg_index)
            REG_COMB_LEN_A:    cfg_comb_len_in[0] = pwdata[COMB_LW-1:0];
            REG_COMB_LEN_B:    cfg_comb_len_in[1] = pwdata[COMB_LW-1:0];
            REG_COMB_LEN_C:    cfg_comb_len_in[2] = pwdata[COMB_LW-1:0];
            REG_COMB_LEN_D:    cfg_comb_len_in[3] = pwdata[COMB_LW-1:0];
            REG_AP_LEN_A:      cfg_ap_len_in[0]   = pwdata[AP_LW-1:0];
            REG_AP_LEN_B:      cfg_ap_len_in[1]   = pwdata[AP_LW-1:0];
            REG_COMB_FEEDBACK: cfg_fb_in          = pwdata[FB_W-1:0];
            REG_WET_AMOUNT:    cfg_amt_in         = pwdata[AMT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (cfg_index)
         REG_COMB_LEN_A:    prdata = DATA_W'(cfg_comb_len_ff[0]);
         REG_COMB_LEN_B:    prdata = DATA_W'(cfg_comb_len_ff[1]);
         REG_COMB_LEN_C:    prdata = DATA_W'(cfg_comb_len_ff[2]);
         REG_COMB_LEN_D:    prdata = DATA_W'(cfg_comb_len_ff[3]);
         REG_AP_LEN_A:      prdata = DATA_W'(cfg_ap_len_ff[0]);
         REG_AP_LEN_B:      prdata = DATA_W'(cfg_ap_len_ff[1]);
         REG_COMB_FEEDBACK: prdata = DATA_W'(cfg_fb_ff);
         REG_WET_AMOUNT:    prdata = DATA_W'(cfg_amt_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_comb_len_ff <= COMB_LEN_RESET;
         cfg_ap_len_ff   <= AP_LEN_RESET;
         cfg_fb_ff       <= FB_RESET;
         cfg_amt_ff      <= AMT_RESET;
      end else begin
         cfg_comb_len_ff <= cfg_comb_len_in;
         cfg_ap_len_ff   <= cfg_ap_len_in;
         cfg_fb_ff       <= cfg_fb_in;
         cfg_amt_ff      <= cfg_amt_in;
      end
   end

   // ------------------------------------------------------------------
   // Flow control. A request is never taken in the cycle straight after
   // another one, nor while the memories are being cleared, nor when four
   // requests already hold a place in the pipeline or the output queue.
   // Counting places this way means the queue can never overflow.
   // ------------------------------------------------------------------
   assign req_stall  = clearing_ff || gap_ff || (outstanding_ff == OUT_CW'(OUT_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (outq_cnt_ff != '0);
   assign rsp_pop    = rsp_valid && !rsp_stall;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_accept && !rsp_pop) begin
         outstanding_in = outstanding_ff + OUT_CW'(1);
      end else if (!req_accept && rsp_pop) begin
         outstanding_in = outstanding_ff - OUT_CW'(1);
      end
   end

   // The clearing pass walks every address once, zeroing all banks together;
   // the allpass banks are simply rewritten with zeros as the index wraps.
   always_comb begin
      clr_idx_in  = clr_idx_ff + COMB_AW'(1);
      clearing_in = clearing_ff && (clr_idx_ff != COMB_AW'(COMB_DEPTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff    <= 1'b1;
         clr_idx_ff     <= '0;
         gap_ff         <= 1'b0;
         outstanding_ff <= '0;
      end else begin
         clearing_ff    <= clearing_in;
         clr_idx_ff     <= clr_idx_in;
         gap_ff         <= req_accept;
         outstanding_ff <= outstanding_in;
      end
   end

   // ------------------------------------------------------------------
   // Cursor handling at the accept edge. A cursor left beyond a shortened
   // line starts again from zero; a bypassed line keeps its cursor.
   // ------------------------------------------------------------------
   always_comb begin
      for (int k = 0; k < NUM_COMBS; k++) begin
         comb_len_sat[k] = (cfg_comb_len_ff[k] > COMB_LW'(COMB_DEPTH)) ?
                           COMB_LW'(COMB_DEPTH) : cfg_comb_len_ff[k];
         comb_act[k]     = (cfg_comb_len_ff[k] != '0);
         comb_cur_eff[k] = ({1'b0, comb_cur_ff[k]} >= comb_len_sat[k]) ? '0 : comb_cur_ff[k];
         comb_cur_inc[k] = {1'b0, comb_cur_eff[k]} + COMB_LW'(1);
         comb_cur_in[k]  = comb_cur_ff[k];
         if (req_accept && comb_act[k]) begin
            comb_cur_in[k] = (comb_cur_inc[k] >= comb_len_sat[k]) ?
                             '0 : comb_cur_inc[k][COMB_AW-1:0];
         end
      end
      for (int j = 0; j < NUM_AP; j++) begin
         ap_len_sat[j] = (cfg_ap_len_ff[j] > AP_LW'(AP_DEPTH)) ?
                         AP_LW'(AP_DEPTH) : cfg_ap_len_ff[j];
         ap_act[j]     = (cfg_ap_len_ff[j] != '0);
         ap_cur_eff[j] = ({1'b0, ap_cur_ff[j]} >= ap_len_sat[j]) ? '0 : ap_cur_ff[j];
         ap_cur_inc[j] = {1'b0, ap_cur_eff[j]} + AP_LW'(1);
         ap_cur_in[j]  = ap_cur_ff[j];
         if (req_accept && ap_act[j]) begin
            ap_cur_in[j] = (ap_cur_inc[j] >= ap_len_sat[j]) ? '0 : ap_cur_inc[j][AP_AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_COMBS; k++) begin
            comb_cur_ff[k] <= '0;
         end
         for (int j = 0; j < NUM_AP; j++) begin
            ap_cur_ff[j] <= '0;
         end
      end else begin
         comb_cur_ff <= comb_cur_in;
         ap_cur_ff   <= ap_cur_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: the comb words read at the accept edge are scaled by the
   // feedback gain, added to the dry sample and written back at the end of
   // this cycle. As requests are never taken back to back, the next request
   // always reads the updated word, even for a line of length one. The wet
   // value is a quarter of each active comb's delayed word; the sum of four
   // such terms always fits the line width.
   // ------------------------------------------------------------------
   always_comb begin
      wet_sum_in = '0;
      for (int k = 0; k < NUM_COMBS; k++) begin
         comb_prod[k]  = comb_rd_ff[k] * $signed({1'b0, cfg_fb_ff});
         comb_wr_in[k] = sat_line(
            {{(LINE_W + 1 - SAMPLE_W){s1_dry_ff[SAMPLE_W-1]}}, s1_dry_ff} +
            {comb_prod[k][FB_W+LINE_W-1], comb_prod[k][FB_W+LINE_W-1:FB_W]});
         if (s1_comb_act_ff[k]) begin
            wet_sum_in = wet_sum_in +
                         {{2{comb_rd_ff[k][LINE_W-1]}}, comb_rd_ff[k][LINE_W-1:2]};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_COMBS; k++) begin
         if (clearing_ff) begin
            comb_mem[k][clr_idx_ff] <= '0;
         end else if (v1_ff && s1_comb_act_ff[k]) begin
            comb_mem[k][s1_comb_addr_ff[k]] <= comb_wr_in[k];
         end
         if (req_accept) begin
            comb_rd_ff[k] <= comb_mem[k][comb_cur_eff[k]];
         end
      end
   end

   // ------------------------------------------------------------------
   // Allpass banks. Each bank is read in the cycle before its stage computes,
   // and written at the end of that stage, so successive requests never
   // overlap on the same word.
   // ------------------------------------------------------------------
   always_comb begin
      ap_a_wr_in  = sat_line({s2_wet_ff[LINE_W-1], s2_wet_ff} +
                             {{2{ap_rd_ff[0][LINE_W-1]}}, ap_rd_ff[0][LINE_W-1:1]});
      ap_a_out_in = s2_wet_ff;
      if (s2_ap_act_ff[0]) begin
         ap_a_out_in = sat_line({ap_rd_ff[0][LINE_W-1], ap_rd_ff[0]} -
                                {{2{s2_wet_ff[LINE_W-1]}}, s2_wet_ff[LINE_W-1:1]});
      end
      ap_b_wr_in  = sat_line({s3_wet_ff[LINE_W-1], s3_wet_ff} +
                             {{2{ap_rd_ff[1][LINE_W-1]}}, ap_rd_ff[1][LINE_W-1:1]});
      ap_b_out_in = s3_wet_ff;
      if (s3_ap_act_ff) begin
         ap_b_out_in = sat_line({ap_rd_ff[1][LINE_W-1], ap_rd_ff[1]} -
                                {{2{s3_wet_ff[LINE_W-1]}}, s3_wet_ff[LINE_W-1:1]});
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         ap_mem[0][clr_idx_ff[AP_AW-1:0]] <= '0;
         ap_mem[1][clr_idx_ff[AP_AW-1:0]] <= '0;
      end else begin
         if (v2_ff && s2_ap_act_ff[0]) begin
            ap_mem[0][s2_ap_addr_ff[0]] <= ap_a_wr_in;
         end
         if (v3_ff && s3_ap_act_ff) begin
            ap_mem[1][s3_ap_addr_ff] <= ap_b_wr_in;
         end
      end
      if (v1_ff) begin
         ap_rd_ff[0] <= ap_mem[0][s1_ap_addr_ff[0]];
      end
      if (v2_ff) begin
         ap_rd_ff[1] <= ap_mem[1][s2_ap_addr_ff[1]];
      end
   end

   // ------------------------------------------------------------------
   // Mix: dry*(1 - amount/2) + wet*amount, formed as two products over a
   // common 2^17 scale, then floored and saturated to the sample width.
   // ------------------------------------------------------------------
   always_comb begin
      amt_sat  = (cfg_amt_ff > AMT_MAX) ? AMT_MAX : cfg_amt_ff;
      gain_dry = GAIN_ONE - {1'b0, amt_sat};
      gain_wet = {amt_sat, 1'b0};
      p_dry_in = s4_dry_ff * $signed({1'b0, gain_dry});
      p_wet_in = s4_wet_ff * $signed({1'b0, gain_wet});
      mix_sum  = {{(MIX_W - DRY_PROD_W){p_dry_ff[DRY_PROD_W-1]}}, p_dry_ff} +
                 {{(MIX_W - WET_PROD_W){p_wet_ff[WET_PROD_W-1]}}, p_wet_ff};
      mix_in   = sat_sample(mix_sum[MIX_W-1:MIX_SHIFT]);
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= req_accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_dry_ff       <= req_in_sample;
         s1_comb_act_ff  <= comb_act;
         s1_comb_addr_ff <= comb_cur_eff;
         s1_ap_act_ff    <= ap_act;
         s1_ap_addr_ff   <= ap_cur_eff;
      end
      if (v1_ff) begin
         s2_dry_ff     <= s1_dry_ff;
         s2_wet_ff     <= wet_sum_in;
         s2_ap_act_ff  <= s1_ap_act_ff;
         s2_ap_addr_ff <= s1_ap_addr_ff;
      end
      if (v2_ff) begin
         s3_dry_ff     <= s2_dry_ff;
         s3_wet_ff     <= ap_a_out_in;
         s3_ap_act_ff  <= s2_ap_act_ff[1];
         s3_ap_addr_ff <= s2_ap_addr_ff[1];
      end
      if (v3_ff) begin
         s4_dry_ff <= s3_dry_ff;
         s4_wet_ff <= ap_b_out_in;
      end
      if (v4_ff) begin
         p_dry_ff <= p_dry_in;
         p_wet_ff <= p_wet_in;
      end
   end

   // ------------------------------------------------------------------
   // Output queue. The head entry drives the result port and stays put
   // while rsp_stall is high.
   // ------------------------------------------------------------------
   assign rsp_out_sample = outq_ff[outq_rd_ff];

   always_comb begin
      outq_cnt_in = outq_cnt_ff;
      if (v5_ff && !rsp_pop) begin
         outq_cnt_in = outq_cnt_ff + OUT_CW'(1);
      end else if (!v5_ff && rsp_pop) begin
         outq_cnt_in = outq_cnt_ff - OUT_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (v5_ff) begin
         outq_ff[outq_wr_ff] <= mix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outq_wr_ff  <= '0;
         outq_rd_ff  <= '0;
         outq_cnt_ff <= '0;
      end else begin
         if (v5_ff) begin
            outq_wr_ff <= outq_wr_ff + OUT_AW'(1);
         end
         if (rsp_pop) begin
            outq_rd_ff <= outq_rd_ff + OUT_AW'(1);
         end
         outq_cnt_ff <= outq_cnt_in;
      end
   end

endmodule
`default_nettype wire
